### sv/sus_pkg.sv
// Package for the sorted unique set: status codes, control types, FSM states.
`default_nettype none
package sus_pkg;

  localparam int unsigned StatusW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OutCntW = 5;

  localparam logic [StatusW-1:0] StInserted  = 3'd0;
  localparam logic [StatusW-1:0] StDuplicate = 3'd1;
  localparam logic [StatusW-1:0] StFull      = 3'd2;
  localparam logic [StatusW-1:0] StListed    = 3'd3;
  localparam logic [StatusW-1:0] StEmpty     = 3'd4;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     ins;
    logic                     shift;
    logic signed [ValueW-1:0] value;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

endpackage
`default_nettype wire

### sv/sus_cell.sv
// One cell of the sorted chain: holds one entry and compares it with the key.
`default_nettype none
module sus_cell (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire sus_pkg::cell_ctl_t                     ctl_i,
  input  wire logic                                   left_lt_i,
  input  wire logic                                   left_valid_i,
  input  wire logic signed [sus_pkg::ValueW-1:0]      left_value_i,
  input  wire logic                                   right_valid_i,
  input  wire logic signed [sus_pkg::ValueW-1:0]      right_value_i,
  output logic                                        lt_o,
  output logic                                        eq_o,
  output logic                                        valid_o,
  output logic signed [sus_pkg::ValueW-1:0]           value_o
);

  logic                                valid_q, valid_d;
  logic signed [sus_pkg::ValueW-1:0]   value_q, value_d;
  logic                                value_en;

  // An empty cell counts as greater than any key.
  assign lt_o    = !valid_q || (ctl_i.value < value_q);
  assign eq_o    = valid_q && (ctl_i.value == value_q);
  assign valid_o = valid_q;
  assign value_o = value_q;

  always_comb begin
    valid_d  = valid_q;
    value_d  = value_q;
    value_en = 1'b0;
    if (ctl_i.shift) begin
      valid_d  = right_valid_i;
      value_d  = right_value_i;
      value_en = 1'b1;
    end else if (ctl_i.ins) begin
      valid_d = valid_q || left_valid_i;
      if (left_lt_i) begin
        value_d  = left_value_i;
        value_en = 1'b1;
      end else if (lt_o) begin
        value_d  = ctl_i.value;
        value_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (value_en) begin
      value_q <= value_d;
    end
  end

endmodule
`default_nettype wire

### sv/sorted_unique_set_insert_top.sv
// Top level of the sorted unique set: cell chain, controller and output register.
//
// Usage: a bounded ascending set of distinct signed 32-bit values.
// Input channel (in_valid_i / in_stall_o) carries number_i and finish_i.
// With finish_i low, the number is inserted in order, or rejected as a
// duplicate or because the set is full; one status transaction results.
// With finish_i high, every stored value is sent in ascending order with
// last_o on the final one (or one empty status if nothing is stored), and
// the set is then clear.
// Output channel (out_valid_o / out_stall_i) carries status_o, number_out_o,
// stored_count_o and last_o from one output register.
// Timing: an insert or empty status is presented the cycle after its input
// transaction; the first value of a finish is loaded from the list state,
// since the finish transaction only starts the listing.
// Throughput: one insert per cycle while the receiver takes results, since
// all cells compare the key in parallel and the chain shifts in the same
// cycle. A finish over n entries then stalls the input while the list state
// shifts one cell per free output cycle, until the last value is loaded.
// Reset: asynchronous, active low; the set comes up empty and no result is
// pending. When the receiver stalls, the output register holds its result
// and the input is stalled until that result is taken.
`default_nettype none
module sorted_unique_set_insert_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [sus_pkg::ValueW-1:0]    number_i,
  input  wire logic                                 finish_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [sus_pkg::StatusW-1:0]               status_o,
  output logic signed [sus_pkg::ValueW-1:0]         number_out_o,
  output logic [sus_pkg::OutCntW-1:0]               stored_count_o,
  output logic                                      last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  sus_pkg::state_e   state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;

  logic                                out_valid_q, out_valid_d;
  logic [sus_pkg::StatusW-1:0]         status_q, status_d;
  logic signed [sus_pkg::ValueW-1:0]   number_q, number_d;
  logic [sus_pkg::OutCntW-1:0]         cnt_out_q, cnt_out_d;
  logic                                last_q, last_d;
  logic                                out_load;

  logic                in_acc;
  logic                out_free;
  logic                dup;
  logic                full;
  sus_pkg::cell_ctl_t  ctl;

  logic [CAPACITY-1:0]               lt_w;
  logic [CAPACITY-1:0]               eq_w;
  logic [CAPACITY-1:0]               valid_w;
  logic signed [sus_pkg::ValueW-1:0] value_w [CAPACITY];

  // Cell chain: cell 0 holds the smallest value and feeds the output on list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                left_lt, left_valid, right_valid;
    logic signed [sus_pkg::ValueW-1:0]   left_value, right_value;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b0;
      assign left_valid = 1'b1;
      assign left_value = '0;
    end else begin : g_body
      assign left_lt    = lt_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_value = value_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_value = '0;
    end else begin : g_mid
      assign right_valid = valid_w[i+1];
      assign right_value = value_w[i+1];
    end

    sus_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_lt_i     (left_lt),
      .left_valid_i  (left_valid),
      .left_value_i  (left_value),
      .right_valid_i (right_valid),
      .right_value_i (right_value),
      .lt_o          (lt_w[i]),
      .eq_o          (eq_w[i]),
      .valid_o       (valid_w[i]),
      .value_o       (value_w[i])
    );
  end

  assign dup  = |eq_w;
  assign full = (count_q == CntW'(CAPACITY));

  // Hold the input while listing or while a result waits on a stalled receiver.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != sus_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sus_pkg::ST_IDLE: begin
        if (in_acc && finish_i && (count_q != '0)) begin
          state_d = sus_pkg::ST_LIST;
        end
      end
      sus_pkg::ST_LIST: begin
        if (out_free && (count_q == CntW'(1))) begin
          state_d = sus_pkg::ST_IDLE;
        end
      end
      default: state_d = sus_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: cell control, count and result register loads.
  always_comb begin
    ctl.ins     = 1'b0;
    ctl.shift   = 1'b0;
    ctl.value   = number_i;
    count_d     = count_q;
    out_load    = 1'b0;
    status_d    = status_q;
    number_d    = number_q;
    cnt_out_d   = cnt_out_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      sus_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          number_d    = number_i;
          cnt_out_d   = sus_pkg::OutCntW'(count_q);
          if (finish_i) begin
            // Empty store gives a single empty status; otherwise start listing.
            if (count_q == '0) begin
              out_load  = 1'b1;
              status_d  = sus_pkg::StEmpty;
              number_d  = '0;
              cnt_out_d = '0;
            end else begin
              out_load    = 1'b0;
              out_valid_d = out_valid_q && out_stall_i;
              status_d    = status_q;
              number_d    = number_q;
              cnt_out_d   = cnt_out_q;
              last_d      = last_q;
            end
          end else if (dup) begin
            status_d = sus_pkg::StDuplicate;
          end else if (full) begin
            status_d = sus_pkg::StFull;
          end else begin
            ctl.ins   = 1'b1;
            count_d   = count_q + CntW'(1);
            status_d  = sus_pkg::StInserted;
            cnt_out_d = sus_pkg::OutCntW'(count_q + CntW'(1));
          end
        end
      end
      sus_pkg::ST_LIST: begin
        // Advance the chain one cell per free output slot.
        if (out_free) begin
          ctl.shift   = 1'b1;
          count_d     = count_q - CntW'(1);
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          status_d    = sus_pkg::StListed;
          number_d    = value_w[0];
          cnt_out_d   = '0;
          last_d      = (count_q == CntW'(1));
        end
      end
      default: begin
        ctl.ins = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sus_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      number_q  <= number_d;
      cnt_out_q <= cnt_out_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign number_out_o   = number_q;
  assign stored_count_o = cnt_out_q;
  assign last_o         = last_q;

  // Occupancy never exceeds the cell count.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("occupancy above capacity");

  // Valid cells always match the occupancy count.
  a_valid_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == 32'(count_q))
    else $error("cell valid bits disagree with occupancy");

  // No input transaction is taken while listing.
  a_list_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sus_pkg::ST_LIST) |-> in_stall_o)
    else $error("input accepted during list");

  // An insert grows the set by exactly one entry.
  a_insert_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow occupancy by one");

endmodule
`default_nettype wire

### sim/sorted_unique_set_insert_top_tb.sv
// Testbench for the sorted unique set: random and directed inserts and finishes, scoreboard check.
`timescale 1ns / 1ps
module sorted_unique_set_insert_top_tb;

  localparam int SetCap        = 16;
  localparam int RandomItems   = 150;
  localparam int PhaseLen      = 64;    // transactions per idling profile
  localparam int WatchdogLimit = 3000;  // cycles without any transaction
  localparam int SettleCycles  = 20;    // quiet cycles after the last result

  // One output transaction as the block presents it.
  typedef struct packed {
    logic [sus_pkg::StatusW-1:0]        status;
    logic signed [sus_pkg::ValueW-1:0]  value;
    logic [sus_pkg::OutCntW-1:0]        count;
    logic                               last;
  } set_result_t;

  // Scoreboard: mirror the stored set and queue the results each input implies.
  class set_scoreboard;
    logic signed [sus_pkg::ValueW-1:0] members[$];  // kept in ascending order
    set_result_t                       awaited[$];
    int                                mismatches = 0;

    function void push_result(logic [sus_pkg::StatusW-1:0] st,
                              logic signed [sus_pkg::ValueW-1:0] v,
                              int cnt, logic lst);
      set_result_t r;
      r.status = st;
      r.value  = v;
      r.count  = cnt[sus_pkg::OutCntW-1:0];
      r.last   = lst;
      awaited.push_back(r);
    endfunction

    function void note_input(logic signed [sus_pkg::ValueW-1:0] num, logic fin);
      int  pos;
      bit  found;
      if (fin) begin
        // Finish: list everything in order, or report empty; the set is then clear.
        if (members.size() == 0) begin
          push_result(sus_pkg::StEmpty, '0, 0, 1'b1);
        end else begin
          foreach (members[i]) begin
            push_result(sus_pkg::StListed, members[i], 0, i == members.size() - 1);
          end
        end
        members.delete();
        return;
      end
      found = 1'b0;
      foreach (members[i]) begin
        if (members[i] == num) found = 1'b1;
      end
      // Duplicate check wins over the full check.
      if (found) begin
        push_result(sus_pkg::StDuplicate, num, members.size(), 1'b1);
      end else if (members.size() >= SetCap) begin
        push_result(sus_pkg::StFull, num, members.size(), 1'b1);
      end else begin
        pos = 0;
        while (pos < members.size() && !(num < members[pos])) pos++;
        members.insert(pos, num);
        push_result(sus_pkg::StInserted, num, members.size(), 1'b1);
      end
    endfunction

    function void check_result(logic [sus_pkg::StatusW-1:0] st,
                               logic signed [sus_pkg::ValueW-1:0] v,
                               logic [sus_pkg::OutCntW-1:0] cnt, logic lst);
      set_result_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d number_out %0d stored_count %0d last %0b",
               st, v, cnt, lst);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (exp.status !== st) begin
        $error("status: expected %0d, actual %0d", exp.status, st);
        mismatches++;
      end
      if (exp.value !== v) begin
        $error("number_out: expected %0d, actual %0d", exp.value, v);
        mismatches++;
      end
      if (exp.count !== cnt) begin
        $error("stored_count: expected %0d, actual %0d", exp.count, cnt);
        mismatches++;
      end
      if (exp.last !== lst) begin
        $error("last: expected %0b, actual %0b", exp.last, lst);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [sus_pkg::ValueW-1:0]   number_i;
  logic                                finish_i;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [sus_pkg::StatusW-1:0]         status_o;
  logic signed [sus_pkg::ValueW-1:0]   number_out_o;
  logic [sus_pkg::OutCntW-1:0]         stored_count_o;
  logic                                last_o;

  set_scoreboard sb;
  int            send_idle_pct = 34;  // chance per cycle that the sender holds off
  int            stall_pct     = 75;  // chance per cycle that the receiver stalls
  int            items_sent    = 0;
  int            quiet_cycles  = 0;

  sorted_unique_set_insert_top #(.CAPACITY(SetCap)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_i       (number_i),
    .finish_i       (finish_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .number_out_o   (number_out_o),
    .stored_count_o (stored_count_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver side and watchdog. Sample right after the edge, so every value
  // read here is the one the block saw at that edge; drive stall with NBAs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, number_out_o, stored_count_o, last_o);
      end
      // Reset the watchdog on any transaction on either channel.
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Hold the input channel idle until every awaited result has arrived.
  // Always advance at least one edge, so valid is never dropped and raised
  // again within the same time step.
  task automatic wait_for_drain();
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  // Present one input transaction and hold it until the block takes it.
  task automatic send_item(input logic signed [sus_pkg::ValueW-1:0] num, input logic fin);
    // Switch idling profile at phase boundaries; drain first, so the sender
    // pauses at least once with nothing left in flight.
    if (items_sent == PhaseLen || items_sent == 2 * PhaseLen) begin
      in_valid_i <= 1'b0;
      wait_for_drain();
      if (items_sent == PhaseLen) begin
        send_idle_pct = 75;
        stall_pct     = 34;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      number_i   <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= num;
    finish_i   <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(num, fin);
    items_sent++;
  endtask

  // Half small values near zero to provoke duplicates, the rest full range
  // or hugging the signed extremes.
  function automatic logic signed [sus_pkg::ValueW-1:0] random_value();
    case ($urandom_range(0, 3))
      0, 1:    random_value = $signed($urandom_range(0, 24)) - 12;
      2:       random_value = $urandom;
      default: random_value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                  : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    int rand_sent;
    int burst;
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    number_i    = '0;
    finish_i    = 1'b0;
    rand_sent   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes and zero, a duplicate, fill to capacity, duplicate
    // and plain insert while full, finish with a junk number, finish on empty.
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    for (int k = 0; k < SetCap - 5; k++) begin
      send_item(32'sd1000 * (k - 5) + 32'sd3, 1'b0);
    end
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sd42, 1'b0);
    send_item(32'shFFFF_FFFF, 1'b1);
    send_item(32'sh5A5A_5A5A, 1'b1);

    // Random: bursts of inserts, now and then past capacity, each closed by a
    // finish; a zero-length burst gives a finish on an empty set.
    while (rand_sent < RandomItems) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 7);
      for (int k = 0; k < burst; k++) begin
        send_item(random_value(), 1'b0);
        rand_sent++;
      end
      send_item($urandom, 1'b1);
      rand_sent++;
    end
    in_valid_i <= 1'b0;

    // Drain, then give any stray result time to show up.
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/sus_pkg.sv
sv/sus_cell.sv
sv/sorted_unique_set_insert_top.sv
sim/sorted_unique_set_insert_top_tb.sv
